>>> hdl/euler_angles_to_basis_vectors_assert.svh
// assertion macros shared by the euler-angle basis design
`ifndef EULER_ANGLES_TO_BASIS_VECTORS_ASSERT_SVH
`define EULER_ANGLES_TO_BASIS_VECTORS_ASSERT_SVH

// clocked assertion, disabled while in reset
`define EAB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// value stays inside the closed range lo..hi whenever en is high
`define EAB_ASSERT_RANGE(lbl, en, val, lo, hi, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (en) |-> (((val) >= (lo)) && ((val) <= (hi)))) else $error(msg);

`endif

>>> hdl/eab_pkg.sv
// types, constants and rounding helpers for the euler-angle basis design
package eab_pkg;

    localparam int TURN_UNITS     = 46080;
    localparam int HALF_TURN      = 23040;
    localparam int QUARTER_TURN   = 11520;
    localparam int CORDIC_STAGES  = 16;
    localparam int LANES          = 3;
    localparam logic signed [31:0] CORDIC_X_START = 32'sd652032854;
    localparam logic signed [16:0] Q15_ONE = 17'sd32768;
    localparam logic signed [15:0] Q14_ONE = 16'sd16384;

    // sine and cosine of the three angles, Q15
    typedef struct packed {
        logic               valid;
        logic signed [16:0] sp;
        logic signed [16:0] cp;
        logic signed [16:0] sy;
        logic signed [16:0] cy;
        logic signed [16:0] sr;
        logic signed [16:0] cr;
    } trig_t;

    // the three basis vectors, Q1.14
    typedef struct packed {
        logic               valid;
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] fz;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic signed [15:0] rz;
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic signed [15:0] uz;
    } basis_t;

    // rounded atan(2^-i) in 2^-16 degree
    function automatic logic signed [24:0] atan_step(input logic [3:0] i);
        logic signed [24:0] v;
        case (i)
            4'd0:    v = 25'sd2949120;
            4'd1:    v = 25'sd1740967;
            4'd2:    v = 25'sd919879;
            4'd3:    v = 25'sd466945;
            4'd4:    v = 25'sd234379;
            4'd5:    v = 25'sd117304;
            4'd6:    v = 25'sd58666;
            4'd7:    v = 25'sd29335;
            4'd8:    v = 25'sd14668;
            4'd9:    v = 25'sd7334;
            4'd10:   v = 25'sd3667;
            4'd11:   v = 25'sd1833;
            4'd12:   v = 25'sd917;
            4'd13:   v = 25'sd458;
            4'd14:   v = 25'sd229;
            4'd15:   v = 25'sd115;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

    // q30 to q14, round half up, saturate
    function automatic logic signed [15:0] rnd_q30(input logic signed [33:0] v);
        logic signed [33:0] t;
        t = (v + 34'sd32768) >>> 16;
        if (t > 34'sd16384)
            t = 34'sd16384;
        else if (t < -34'sd16384)
            t = -34'sd16384;
        return t[15:0];
    endfunction

    // q45 to q14, round half up, saturate
    function automatic logic signed [15:0] rnd_q45(input logic signed [51:0] v);
        logic signed [51:0] t;
        t = (v + 52'sh4000_0000) >>> 31;
        if (t > 52'sd16384)
            t = 52'sd16384;
        else if (t < -52'sd16384)
            t = -52'sd16384;
        return t[15:0];
    endfunction

endpackage

>>> hdl/eab_trig.sv
// angle reduction and pipelined cordic sine/cosine for three angles
module eab_trig
    import eab_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ce,
    input  logic               in_valid,
    input  logic signed [16:0] pitch_angle,
    input  logic signed [16:0] yaw_angle,
    input  logic signed [16:0] roll_angle,
    output trig_t              trig
);

    logic signed [16:0] ang [LANES];
    logic signed [17:0] r_half [LANES];
    logic signed [17:0] r_quad [LANES];
    logic               fold [LANES];

    logic               valid_reg [CORDIC_STAGES+2];
    logic signed [31:0] x_reg [CORDIC_STAGES+1][LANES];
    logic signed [31:0] y_reg [CORDIC_STAGES+1][LANES];
    logic signed [24:0] z_reg [CORDIC_STAGES+1][LANES];
    logic               flip_reg [CORDIC_STAGES+1][LANES];
    logic signed [16:0] s_reg [LANES];
    logic signed [16:0] c_reg [LANES];

    // q30 to q15 with optional negation, round half up, saturate
    function automatic logic signed [16:0] rnd_q15(input logic signed [31:0] v,
                                                   input logic neg);
        logic signed [32:0] w;
        logic signed [32:0] t;
        w = neg ? -33'(v) : 33'(v);
        t = (w + 33'sd16384) >>> 15;
        if (t > 33'(Q15_ONE))
            t = 33'(Q15_ONE);
        else if (t < -33'(Q15_ONE))
            t = -33'(Q15_ONE);
        return t[16:0];
    endfunction

    assign ang[0] = pitch_angle;
    assign ang[1] = yaw_angle;
    assign ang[2] = roll_angle;

    // reduce to [-half, half) then fold into [-quarter, quarter]
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            r_half[l] = 18'(ang[l]);
            if (r_half[l] >= 18'(HALF_TURN))
                r_half[l] = r_half[l] - 18'(TURN_UNITS);
            else if (r_half[l] < -18'(HALF_TURN))
                r_half[l] = r_half[l] + 18'(TURN_UNITS);
            r_quad[l] = r_half[l];
            fold[l]   = 1'b0;
            if (r_half[l] > 18'(QUARTER_TURN))
            begin
                r_quad[l] = r_half[l] - 18'(HALF_TURN);
                fold[l]   = 1'b1;
            end
            else if (r_half[l] < -18'(QUARTER_TURN))
            begin
                r_quad[l] = r_half[l] + 18'(HALF_TURN);
                fold[l]   = 1'b1;
            end
        end
    end

    // valid bits follow the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < CORDIC_STAGES + 2; s++)
                valid_reg[s] <= 1'b0;
        end
        else if (ce)
        begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s < CORDIC_STAGES + 2; s++)
                valid_reg[s] <= valid_reg[s-1];
        end
    end

    // reduction, one cordic iteration per stage, final rounding
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                x_reg[0][l]    <= CORDIC_X_START;
                y_reg[0][l]    <= 32'sd0;
                z_reg[0][l]    <= 25'(r_quad[l]) <<< 9;
                flip_reg[0][l] <= fold[l];
            end
            for (int s = 0; s < CORDIC_STAGES; s++)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    flip_reg[s+1][l] <= flip_reg[s][l];
                    if (z_reg[s][l] >= 25'sd0)
                    begin
                        x_reg[s+1][l] <= x_reg[s][l] - (y_reg[s][l] >>> s);
                        y_reg[s+1][l] <= y_reg[s][l] + (x_reg[s][l] >>> s);
                        z_reg[s+1][l] <= z_reg[s][l] - atan_step(4'(s));
                    end
                    else
                    begin
                        x_reg[s+1][l] <= x_reg[s][l] + (y_reg[s][l] >>> s);
                        y_reg[s+1][l] <= y_reg[s][l] - (x_reg[s][l] >>> s);
                        z_reg[s+1][l] <= z_reg[s][l] + atan_step(4'(s));
                    end
                end
            end
            for (int l = 0; l < LANES; l++)
            begin
                c_reg[l] <= rnd_q15(x_reg[CORDIC_STAGES][l], flip_reg[CORDIC_STAGES][l]);
                s_reg[l] <= rnd_q15(y_reg[CORDIC_STAGES][l], flip_reg[CORDIC_STAGES][l]);
            end
        end
    end

    assign trig.valid = valid_reg[CORDIC_STAGES+1];
    assign trig.sp    = s_reg[0];
    assign trig.cp    = c_reg[0];
    assign trig.sy    = s_reg[1];
    assign trig.cy    = c_reg[1];
    assign trig.sr    = s_reg[2];
    assign trig.cr    = c_reg[2];

endmodule

>>> hdl/eab_basis.sv
// three-stage product and sum pipeline that forms the basis vectors
module eab_basis
    import eab_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   ce,
    input  trig_t  trig,
    output basis_t basis
);

    logic               v1_reg, v2_reg, v3_reg;
    logic signed [33:0] cpcy_reg, cpsy_reg, srcp_reg, crcp_reg, spcy_reg, spsy_reg;
    logic signed [33:0] crsy_reg, crcy_reg, srsy_reg, srcy_reg;
    logic signed [16:0] sr_reg, cr_reg;
    logic signed [15:0] fz_reg;

    logic signed [51:0] t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [33:0] cpcy2_reg, cpsy2_reg, srcp2_reg, crcp2_reg;
    logic signed [33:0] crsy2_reg, crcy2_reg, srsy2_reg, srcy2_reg;
    logic signed [15:0] fz2_reg;

    logic signed [15:0] fx_reg, fy_reg, fz3_reg, rx_reg, ry_reg, rz_reg;
    logic signed [15:0] ux_reg, uy_reg, uz_reg;
    logic signed [17:0] fz_next;

    // forward z is minus sine of pitch, halved with rounding
    assign fz_next = (-18'(trig.sp) + 18'sd1) >>> 1;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (ce)
        begin
            v1_reg <= trig.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage 1: two-factor products
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            cpcy_reg <= trig.cp * trig.cy;
            cpsy_reg <= trig.cp * trig.sy;
            srcp_reg <= trig.sr * trig.cp;
            crcp_reg <= trig.cr * trig.cp;
            spcy_reg <= trig.sp * trig.cy;
            spsy_reg <= trig.sp * trig.sy;
            crsy_reg <= trig.cr * trig.sy;
            crcy_reg <= trig.cr * trig.cy;
            srsy_reg <= trig.sr * trig.sy;
            srcy_reg <= trig.sr * trig.cy;
            sr_reg   <= trig.sr;
            cr_reg   <= trig.cr;
            fz_reg   <= fz_next[15:0];
        end
    end

    // stage 2: three-factor products
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            t1_reg    <= 52'(sr_reg) * 52'(spcy_reg);
            t2_reg    <= 52'(sr_reg) * 52'(spsy_reg);
            t3_reg    <= 52'(cr_reg) * 52'(spcy_reg);
            t4_reg    <= 52'(cr_reg) * 52'(spsy_reg);
            cpcy2_reg <= cpcy_reg;
            cpsy2_reg <= cpsy_reg;
            srcp2_reg <= srcp_reg;
            crcp2_reg <= crcp_reg;
            crsy2_reg <= crsy_reg;
            crcy2_reg <= crcy_reg;
            srsy2_reg <= srsy_reg;
            srcy2_reg <= srcy_reg;
            fz2_reg   <= fz_reg;
        end
    end

    // stage 3: sums, rounding and saturation into the output register
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            fx_reg  <= rnd_q30(cpcy2_reg);
            fy_reg  <= rnd_q30(cpsy2_reg);
            fz3_reg <= fz2_reg;
            rx_reg  <= rnd_q45((52'(crsy2_reg) <<< 15) - t1_reg);
            ry_reg  <= rnd_q45(-t2_reg - (52'(crcy2_reg) <<< 15));
            rz_reg  <= rnd_q30(-srcp2_reg);
            ux_reg  <= rnd_q45(t3_reg + (52'(srsy2_reg) <<< 15));
            uy_reg  <= rnd_q45(t4_reg - (52'(srcy2_reg) <<< 15));
            uz_reg  <= rnd_q30(crcp2_reg);
        end
    end

    always_comb
    begin
        basis.valid = v3_reg;
        basis.fx    = fx_reg;
        basis.fy    = fy_reg;
        basis.fz    = fz3_reg;
        basis.rx    = rx_reg;
        basis.ry    = ry_reg;
        basis.rz    = rz_reg;
        basis.ux    = ux_reg;
        basis.uy    = uy_reg;
        basis.uz    = uz_reg;
    end

endmodule

>>> hdl/euler_angles_to_basis_vectors.sv
// euler angles to forward/right/up vectors: 21 register stages from accept to out_valid
// one transaction per cycle unless stalled; 16-iteration cordic unrolled into stages
// stages: 1 reduction, 16 cordic, 1 rounding, 2 multiply, 1 sum/saturate
// the whole pipeline holds while a finished result waits for out_ready
// asynchronous active-low reset clears all valid bits; payload is not reset
module euler_angles_to_basis_vectors
    import eab_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [16:0] pitch_angle,
    input  logic signed [16:0] yaw_angle,
    input  logic signed [16:0] roll_angle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] forward_x,
    output logic signed [15:0] forward_y,
    output logic signed [15:0] forward_z,
    output logic signed [15:0] right_x,
    output logic signed [15:0] right_y,
    output logic signed [15:0] right_z,
    output logic signed [15:0] up_x,
    output logic signed [15:0] up_y,
    output logic signed [15:0] up_z
);

`include "euler_angles_to_basis_vectors_assert.svh"

    logic   ce;
    trig_t  trig;
    basis_t basis;

    // pipeline advances unless the output holds an untaken result
    assign ce       = !basis.valid || out_ready;
    assign in_ready = ce;

    eab_trig u_trig (
        .clk         (clk),
        .rst_n       (rst_n),
        .ce          (ce),
        .in_valid    (in_valid),
        .pitch_angle (pitch_angle),
        .yaw_angle   (yaw_angle),
        .roll_angle  (roll_angle),
        .trig        (trig)
    );

    eab_basis u_basis (
        .clk   (clk),
        .rst_n (rst_n),
        .ce    (ce),
        .trig  (trig),
        .basis (basis)
    );

    assign out_valid = basis.valid;
    assign forward_x = basis.fx;
    assign forward_y = basis.fy;
    assign forward_z = basis.fz;
    assign right_x   = basis.rx;
    assign right_y   = basis.ry;
    assign right_z   = basis.rz;
    assign up_x      = basis.ux;
    assign up_y      = basis.uy;
    assign up_z      = basis.uz;

    // checks
    `EAB_ASSERT_RANGE(a_sin_range, trig.valid, trig.sp, -17'sd32768, 17'sd32768, "sine out of range")
    `EAB_ASSERT_RANGE(a_fwd_range, out_valid, forward_x, -16'sd16384, 16'sd16384, "forward_x out of range")
    `EAB_ASSERT_RANGE(a_up_range, out_valid, up_y, -16'sd16384, 16'sd16384, "up_y out of range")
    `EAB_ASSERT(a_trig_hold, (trig.valid && !ce) |=> $stable(trig), "stalled trig stage moved")

endmodule
